>>> rtl/core/cer_pkg.sv
// Shared types and constants of the clipped ellipse rasterizer.
// No dependencies; every other file of the block imports this package.
package cer_pkg;

  localparam int unsigned SCR_W     = 11;
  localparam int unsigned COLOR_W   = 16;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [SCR_W-1:0] SCR_RESET = 11'd128;

  typedef enum logic {
    OP_START = 1'b0,
    OP_STEP  = 1'b1
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SCREEN_WIDTH  = 2'd0,
    CFG_SCREEN_HEIGHT = 2'd1
  } cfg_reg_e;

  typedef enum logic [3:0] {
    PH_IDLE = 4'b0001,
    PH_INIT = 4'b0010,
    PH_MAIN = 4'b0100,
    PH_TAIL = 4'b1000
  } phase_e;

  // One step's pixel set handed from the engine to the pixel queue.
  typedef struct packed {
    logic load;
    logic four;
    logic done;
  } set_info_t;

endpackage

>>> rtl/core/cer_if.sv
// Channel interfaces of the clipped ellipse rasterizer: command input,
// pixel output and configuration write. Depends on cer_pkg.
interface cer_in_if import cer_pkg::*; #(
  parameter int unsigned AXIS_BITS  = 10,
  parameter int unsigned COORD_BITS = 12
) ();
  logic                         valid;
  logic                         ready;
  logic                         opcode;
  logic signed [COORD_BITS-1:0] center_x;
  logic signed [COORD_BITS-1:0] center_y;
  logic [AXIS_BITS-1:0]         semi_axis_x;
  logic [AXIS_BITS-1:0]         semi_axis_y;
  logic [COLOR_W-1:0]           pixel_color;

  modport source (output valid, opcode, center_x, center_y, semi_axis_x, semi_axis_y,
                  pixel_color, input ready);
  modport sink   (input valid, opcode, center_x, center_y, semi_axis_x, semi_axis_y,
                  pixel_color, output ready);
endinterface

interface cer_out_if import cer_pkg::*; #(
  parameter int unsigned COORD_BITS = 12
) ();
  logic                       valid;
  logic                       ready;
  logic signed [COORD_BITS:0] pixel_x;
  logic signed [COORD_BITS:0] pixel_y;
  logic [COLOR_W-1:0]         color_out;
  logic                       in_view;
  logic                       last_of_step;
  logic                       done_res;

  modport source (output valid, pixel_x, pixel_y, color_out, in_view, last_of_step,
                  done_res, input ready);
  modport sink   (input valid, pixel_x, pixel_y, color_out, in_view, last_of_step,
                  done_res, output ready);
endinterface

interface cer_cfg_if import cer_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [SCR_W-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> rtl/core/cer_engine.sv
// Ellipse stepping engine: error-term state, one step per accepted step beat,
// and the mirrored pixels with their clip flags. Depends on cer_pkg.
module cer_engine import cer_pkg::*; #(
  parameter int unsigned AXIS_BITS  = 10,
  parameter int unsigned COORD_BITS = 12
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic                         step_i,
  input  logic signed [COORD_BITS-1:0] center_x_i,
  input  logic signed [COORD_BITS-1:0] center_y_i,
  input  logic [AXIS_BITS-1:0]         semi_axis_x_i,
  input  logic [AXIS_BITS-1:0]         semi_axis_y_i,
  input  logic [COLOR_W-1:0]           pixel_color_i,
  input  logic [SCR_W-1:0]             screen_width_i,
  input  logic [SCR_W-1:0]             screen_height_i,
  output logic                         busy_o,
  output set_info_t                    info_o,
  output logic signed [COORD_BITS:0]   pix_x_o [4],
  output logic signed [COORD_BITS:0]   pix_y_o [4],
  output logic                         vis_o [4],
  output logic [COLOR_W-1:0]           color_o
);

  localparam int unsigned AW   = AXIS_BITS;
  localparam int unsigned CW   = COORD_BITS;
  localparam int unsigned OW   = CW + 1;
  localparam int unsigned SQW  = 2 * AW;
  localparam int unsigned EW   = 3 * AW + 10;
  localparam int unsigned PW   = AW + SQW + 4;
  localparam int unsigned BASE = (CW > AW + 1) ? CW : AW + 1;
  localparam int unsigned VW   = ((BASE > SCR_W) ? BASE : SCR_W) + 2;

  phase_e                phase_q, phase_d;
  logic [AW:0]           dx_q, dx_d;
  logic signed [AW+1:0]  dy_q, dy_d;
  logic signed [EW-1:0]  err_q, err_d;
  logic signed [EW-1:0]  tx_q, tx_d;
  logic signed [EW-1:0]  ty_q, ty_d;
  logic [SQW-1:0]        ax2_q, ax2_d;
  logic [SQW-1:0]        ay2_q, ay2_d;
  logic signed [CW-1:0]  cx_q, cx_d;
  logic signed [CW-1:0]  cy_q, cy_d;
  logic [AW-1:0]         a_q, a_d;
  logic [COLOR_W-1:0]    color_q, color_d;

  logic signed [EW-1:0]  ax2_e, ay2_e, ty0, tx_n, ty_n, err_n;
  logic signed [PW-1:0]  ty0_p;
  logic signed [AW+2:0]  twob_m1;
  logic signed [EW:0]    e2, tx_x, neg_ty;
  logic                  mx, my, main_done, tail_done;
  logic [AW:0]           dx_inc, dx_m, dxp;
  logic signed [AW+1:0]  dy_dec, dy_m, dyp;
  logic signed [VW-1:0]  cx_w, cy_w, dxp_w, dyp_w, xp, xm, yp, ym, sw_w, sh_w;
  logic                  xp_v, xm_v, yp_v, ym_v;

  assign ax2_e = signed'({{(EW-SQW){1'b0}}, ax2_q});
  assign ay2_e = signed'({{(EW-SQW){1'b0}}, ay2_q});

  // Start setup: dy holds b here, so (2b-1)*a^2 seeds both the error and
  // the vertical increment term.
  assign twob_m1 = {dy_q, 1'b0} - {{(AW+2){1'b0}}, 1'b1};
  assign ty0_p   = PW'(twob_m1) * PW'(signed'({1'b0, ax2_q}));
  assign ty0     = EW'(ty0_p);

  // Main step. tx tracks (2dx+1)*b^2 and ty tracks (2dy-1)*a^2, so a step
  // needs only adds and compares.
  assign e2     = {err_q, 1'b0};
  assign tx_x   = {tx_q[EW-1], tx_q};
  assign neg_ty = -{ty_q[EW-1], ty_q};
  assign mx     = e2 < tx_x;
  assign my     = e2 > neg_ty;
  assign tx_n   = tx_q + (ay2_e <<< 1);
  assign ty_n   = ty_q - (ax2_e <<< 1);
  assign err_n  = err_q + (mx ? tx_n : '0) - (my ? ty_n : '0);

  assign dx_inc = dx_q + {{AW{1'b0}}, 1'b1};
  assign dy_dec = dy_q - {{(AW+1){1'b0}}, 1'b1};
  assign dx_m   = mx ? dx_inc : dx_q;
  assign dy_m   = my ? dy_dec : dy_q;

  assign main_done = !(mx || my) || (dy_m[AW+1] && !(dx_m < {1'b0, a_q}));
  assign tail_done = dx_inc >= {1'b0, a_q};

  // Pixel positions; the tail phase uses the incremented dx on the center row.
  assign dxp   = (phase_q == PH_TAIL) ? dx_inc : dx_q;
  assign dyp   = (phase_q == PH_TAIL) ? '0 : dy_q;
  assign cx_w  = VW'(cx_q);
  assign cy_w  = VW'(cy_q);
  assign dxp_w = signed'({{(VW-AW-1){1'b0}}, dxp});
  assign dyp_w = VW'(dyp);
  assign xp    = cx_w + dxp_w;
  assign xm    = cx_w - dxp_w;
  assign yp    = cy_w + dyp_w;
  assign ym    = cy_w - dyp_w;
  assign sw_w  = signed'({{(VW-SCR_W){1'b0}}, screen_width_i});
  assign sh_w  = signed'({{(VW-SCR_W){1'b0}}, screen_height_i});
  assign xp_v  = !xp[VW-1] && (xp < sw_w);
  assign xm_v  = !xm[VW-1] && (xm < sw_w);
  assign yp_v  = !yp[VW-1] && (yp < sh_w);
  assign ym_v  = !ym[VW-1] && (ym < sh_w);

  assign pix_x_o[0] = xp[OW-1:0];
  assign pix_y_o[0] = yp[OW-1:0];
  assign vis_o[0]   = xp_v && yp_v;
  assign pix_x_o[1] = xm[OW-1:0];
  assign pix_y_o[1] = yp[OW-1:0];
  assign vis_o[1]   = xm_v && yp_v;
  assign pix_x_o[2] = xm[OW-1:0];
  assign pix_y_o[2] = ym[OW-1:0];
  assign vis_o[2]   = xm_v && ym_v;
  assign pix_x_o[3] = xp[OW-1:0];
  assign pix_y_o[3] = ym[OW-1:0];
  assign vis_o[3]   = xp_v && ym_v;
  assign color_o    = color_q;

  assign busy_o      = (phase_q == PH_INIT);
  assign info_o.load = step_i && ((phase_q == PH_MAIN) || (phase_q == PH_TAIL));
  assign info_o.four = (phase_q == PH_MAIN);
  assign info_o.done = (phase_q == PH_MAIN) ? main_done : tail_done;

  always_comb begin
    phase_d = phase_q;
    dx_d    = dx_q;
    dy_d    = dy_q;
    err_d   = err_q;
    tx_d    = tx_q;
    ty_d    = ty_q;
    ax2_d   = ax2_q;
    ay2_d   = ay2_q;
    cx_d    = cx_q;
    cy_d    = cy_q;
    a_d     = a_q;
    color_d = color_q;
    if (start_i) begin
      phase_d = PH_INIT;
      ax2_d   = SQW'(semi_axis_x_i) * SQW'(semi_axis_x_i);
      ay2_d   = SQW'(semi_axis_y_i) * SQW'(semi_axis_y_i);
      dx_d    = '0;
      dy_d    = signed'({2'b00, semi_axis_y_i});
      cx_d    = center_x_i;
      cy_d    = center_y_i;
      a_d     = semi_axis_x_i;
      color_d = pixel_color_i;
    end else begin
      case (phase_q)
        PH_INIT: begin
          err_d   = ay2_e - ty0;
          tx_d    = ay2_e;
          ty_d    = ty0;
          phase_d = PH_MAIN;
        end
        PH_MAIN: begin
          if (step_i) begin
            dx_d  = dx_m;
            dy_d  = dy_m;
            err_d = err_n;
            if (mx) tx_d = tx_n;
            if (my) ty_d = ty_n;
            if (main_done) begin
              phase_d = PH_IDLE;
            end else if (dy_m[AW+1]) begin
              phase_d = PH_TAIL;
            end
          end
        end
        PH_TAIL: begin
          if (step_i) begin
            dx_d = dx_inc;
            if (tail_done) phase_d = PH_IDLE;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
    end else begin
      phase_q <= phase_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dx_q    <= dx_d;
    dy_q    <= dy_d;
    err_q   <= err_d;
    tx_q    <= tx_d;
    ty_q    <= ty_d;
    ax2_q   <= ax2_d;
    ay2_q   <= ay2_d;
    cx_q    <= cx_d;
    cy_q    <= cy_d;
    a_q     <= a_d;
    color_q <= color_d;
  end

endmodule

>>> rtl/core/cer_pixq.sv
// Pixel queue: holds one step's set of up to four pixels and feeds them, one
// beat per cycle unless stalled, into the output register. Depends on cer_pkg.
module cer_pixq import cer_pkg::*; #(
  parameter int unsigned COORD_BITS = 12
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  set_info_t                  info_i,
  input  logic signed [COORD_BITS:0] pix_x_i [4],
  input  logic signed [COORD_BITS:0] pix_y_i [4],
  input  logic                       vis_i [4],
  input  logic [COLOR_W-1:0]         color_i,
  output logic                       can_load_o,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic signed [COORD_BITS:0] pixel_x_o,
  output logic signed [COORD_BITS:0] pixel_y_o,
  output logic [COLOR_W-1:0]         color_o,
  output logic                       in_view_o,
  output logic                       last_o,
  output logic                       done_o
);

  localparam int unsigned OW = COORD_BITS + 1;

  logic [2:0]           rem_q, rem_d;
  logic [1:0]           rd_q, rd_d;
  logic signed [OW-1:0] bx_q [4];
  logic signed [OW-1:0] by_q [4];
  logic                 bv_q [4];
  logic                 bdone_q;
  logic [COLOR_W-1:0]   bcol_q;
  logic                 ov_q;
  logic signed [OW-1:0] ox_q, oy_q;
  logic [COLOR_W-1:0]   ocol_q;
  logic                 ovis_q, olast_q, odone_q;
  logic                 move, tail_beat;

  assign move       = (rem_q != 3'd0) && (!ov_q || out_ready_i);
  assign tail_beat  = (rem_q == 3'd1);
  assign can_load_o = (rem_q == 3'd0) || (tail_beat && move);

  always_comb begin
    rem_d = rem_q;
    rd_d  = rd_q;
    if (info_i.load) begin
      rem_d = info_i.four ? 3'd4 : 3'd2;
      rd_d  = 2'd0;
    end else if (move) begin
      rem_d = rem_q - 3'd1;
      rd_d  = rd_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q <= 3'd0;
      rd_q  <= 2'd0;
      ov_q  <= 1'b0;
    end else begin
      rem_q <= rem_d;
      rd_q  <= rd_d;
      if (move) begin
        ov_q <= 1'b1;
      end else if (out_ready_i) begin
        ov_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (info_i.load) begin
      bx_q    <= pix_x_i;
      by_q    <= pix_y_i;
      bv_q    <= vis_i;
      bdone_q <= info_i.done;
      bcol_q  <= color_i;
    end
    if (move) begin
      ox_q    <= bx_q[rd_q];
      oy_q    <= by_q[rd_q];
      ovis_q  <= bv_q[rd_q];
      ocol_q  <= bcol_q;
      olast_q <= tail_beat;
      odone_q <= tail_beat && bdone_q;
    end
  end

  assign out_valid_o = ov_q;
  assign pixel_x_o   = ox_q;
  assign pixel_y_o   = oy_q;
  assign color_o     = ocol_q;
  assign in_view_o   = ovis_q;
  assign last_o      = olast_q;
  assign done_o      = odone_q;

endmodule

>>> rtl/core/clipped_ellipse_rasterizer.sv
// Top level of the clipped ellipse rasterizer: screen-size registers, input
// handshake, stepping engine and pixel queue. Depends on cer_pkg, cer_if,
// cer_engine and cer_pixq.
//
// Usage. Commands arrive on in_i. A start beat (opcode OP_START) loads the
// center, both semi-axes and the color; it produces no pixel. Each step beat
// (opcode OP_STEP) produces four mirrored pixels in the main phase or two
// center-row pixels in the tail phase that finishes flat ellipses. Every
// pixel leaves on out_o with an in-view flag from the screen clip test;
// last_of_step marks the final pixel of a step and done_res the final pixel
// of the whole ellipse. Step beats while no ellipse is active are accepted
// and produce nothing. cfg_i writes screen_width and screen_height; it is
// always ready and should be used only while the block is idle.
// Timing. A step is evaluated in the cycle it is accepted; its pixels are
// registered into a four-entry queue and from there move into the output
// register, so the first pixel is valid only after both registers. The output
// port moves one pixel per cycle while the receiver is ready, which sets the
// sustained rate; a new step is taken as the last pixel of a set moves. A start
// holds in_i.ready low in setup, where a single multiply seeds the error term.
// Reset clears the phase, empties the queue and output register and sets both
// screen registers to 128. When the receiver stalls, the current pixel
// holds on out_o, the queue drains into it no further, and in_i.ready drops
// once the queue holds a set that cannot yet move.
module clipped_ellipse_rasterizer import cer_pkg::*; #(
  parameter int unsigned AXIS_BITS  = 10,
  parameter int unsigned COORD_BITS = 12
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  cer_in_if.sink    in_i,
  cer_out_if.source out_o,
  cer_cfg_if.sink   cfg_i
);

  logic [SCR_W-1:0]           screen_width_q, screen_height_q;
  logic                       busy, can_load, in_accept, start, step;
  set_info_t                  info;
  logic signed [COORD_BITS:0] pix_x [4];
  logic signed [COORD_BITS:0] pix_y [4];
  logic                       vis [4];
  logic [COLOR_W-1:0]         set_color;

  // Configuration writes are registered; unknown indexes are dropped.
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      screen_width_q  <= SCR_RESET;
      screen_height_q <= SCR_RESET;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        CFG_SCREEN_WIDTH:  screen_width_q  <= cfg_i.data;
        CFG_SCREEN_HEIGHT: screen_height_q <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // A new command is taken whenever the engine is not seeding a start and
  // the queue can take a fresh pixel set in this cycle.
  assign in_i.ready = !busy && can_load;
  assign in_accept  = in_i.valid && in_i.ready;
  assign start      = in_accept && (in_i.opcode == OP_START);
  assign step       = in_accept && (in_i.opcode == OP_STEP);

  cer_engine #(
    .AXIS_BITS  (AXIS_BITS),
    .COORD_BITS (COORD_BITS)
  ) u_engine (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (start),
    .step_i          (step),
    .center_x_i      (in_i.center_x),
    .center_y_i      (in_i.center_y),
    .semi_axis_x_i   (in_i.semi_axis_x),
    .semi_axis_y_i   (in_i.semi_axis_y),
    .pixel_color_i   (in_i.pixel_color),
    .screen_width_i  (screen_width_q),
    .screen_height_i (screen_height_q),
    .busy_o          (busy),
    .info_o          (info),
    .pix_x_o         (pix_x),
    .pix_y_o         (pix_y),
    .vis_o           (vis),
    .color_o         (set_color)
  );

  cer_pixq #(
    .COORD_BITS (COORD_BITS)
  ) u_pixq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .info_i      (info),
    .pix_x_i     (pix_x),
    .pix_y_i     (pix_y),
    .vis_i       (vis),
    .color_i     (set_color),
    .can_load_o  (can_load),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .pixel_x_o   (out_o.pixel_x),
    .pixel_y_o   (out_o.pixel_y),
    .color_o     (out_o.color_out),
    .in_view_o   (out_o.in_view),
    .last_o      (out_o.last_of_step),
    .done_o      (out_o.done_res)
  );

endmodule

>>> rtl/core/cer_checker.sv
// Port-level checks of the clipped ellipse rasterizer and the bind that
// attaches them to the top level. Depends on cer_pkg.
module cer_checker import cer_pkg::*; #(
  parameter int unsigned OUT_W = 13
) (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid,
  input logic               in_ready,
  input logic               in_opcode,
  input logic               out_valid,
  input logic               out_ready,
  input logic [OUT_W-1:0]   out_x,
  input logic [OUT_W-1:0]   out_y,
  input logic [COLOR_W-1:0] out_color,
  input logic               out_view,
  input logic               out_last,
  input logic               out_done
);

  // A stalled pixel beat stays on the port unchanged.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(out_x) && $stable(out_y) &&
      $stable(out_color) && $stable(out_view) && $stable(out_last) && $stable(out_done))
    else $error("stalled pixel beat changed");

  // The end of an ellipse is always the end of a step.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_done |-> out_last)
    else $error("done_res without last_of_step");

  // A start is followed by the setup phase, in which no command is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && in_ready && (in_opcode == OP_START) |=> !in_ready)
    else $error("command taken during start setup");

endmodule

bind clipped_ellipse_rasterizer cer_checker #(
  .OUT_W (COORD_BITS + 1)
) u_cer_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .in_valid  (in_i.valid),
  .in_ready  (in_i.ready),
  .in_opcode (in_i.opcode),
  .out_valid (out_o.valid),
  .out_ready (out_o.ready),
  .out_x     (out_o.pixel_x),
  .out_y     (out_o.pixel_y),
  .out_color (out_o.color_out),
  .out_view  (out_o.in_view),
  .out_last  (out_o.last_of_step),
  .out_done  (out_o.done_res)
);
